// ----- rtl/ode_integrator_euler_rk2_rk4_macros.svh -----
// ----------------------------------------------------------------------------
// ODE integrator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ODE_INTEGRATOR_EULER_RK2_RK4_MACROS_SVH
`define ODE_INTEGRATOR_EULER_RK2_RK4_MACROS_SVH

// same-cycle implication
`define ODE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ODE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ode_pkg.sv -----
// ----------------------------------------------------------------------------
// ODE integrator package
// Widths, codes, microword types and the microcode program.
// ----------------------------------------------------------------------------
package ode_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int RECIP6_SHIFT = 26;
    localparam int RECIP6       = ((1 << RECIP6_SHIFT) + 3) / 6;  // round(2^26/6)
    localparam int STEP_W       = 11;
    localparam logic [STEP_W-1:0] MAX_STEPS = 11'd1024;

    localparam int ROM_DEPTH = 50;
    localparam int PC_W      = $clog2(ROM_DEPTH);

    // program entry points
    localparam logic [PC_W-1:0] PC_EULER = 6'd0;
    localparam logic [PC_W-1:0] PC_HEUN  = 6'd7;
    localparam logic [PC_W-1:0] PC_RK4   = 6'd21;

    // method codes
    localparam logic [1:0] METH_EULER = 2'd0;
    localparam logic [1:0] METH_HEUN  = 2'd1;
    localparam logic [1:0] METH_RK4   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_METHOD     = 2'd0;
    localparam logic [1:0] CFG_STEP_SIZE  = 2'd1;
    localparam logic [1:0] CFG_STEP_COUNT = 2'd2;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

    typedef enum logic [2:0] {MUL_NONE, MUL_XX, MUL_HK, MUL_HS, MUL_PR} mul_op_t;
    typedef enum logic [1:0] {RND_NONE, RND_F, RND_F1, RND_R6} rnd_op_t;
    typedef enum logic [2:0] {WB_NONE, WB_K, WB_YE, WB_Y, WB_YRAW, WB_P} wb_op_t;
    typedef enum logic [1:0] {XE_NONE, XE_START, XE_MID, XE_FULL} xe_op_t;
    typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD1, ACC_ADD2} acc_op_t;

    typedef struct packed {
        mul_op_t mul;
        rnd_op_t rnd;
        wb_op_t  wb;
        xe_op_t  xe;
        acc_op_t acc;
        logic    last;   // end of one integration step
    } ucode_t;

    localparam ucode_t UC_NOP = '{MUL_NONE, RND_NONE, WB_NONE, XE_NONE, ACC_NONE, 1'b0};

    // saturation check of a 49-bit value against signed 32 bits
    function automatic logic sat_ovf(input logic [48:0] v);
        return !((&v[48:31]) || !(|v[48:31]));
    endfunction

    function automatic logic [31:0] sat_val(input logic [48:0] v);
        logic [31:0] r;
        r = v[31:0];
        if (sat_ovf(v))
        begin
            r = {v[48], {31{~v[48]}}};
        end
        return r;
    endfunction

    function automatic ucode_t mk(input mul_op_t m, input rnd_op_t r, input wb_op_t w,
                                  input xe_op_t x, input acc_op_t a, input logic l);
        ucode_t u;
        u = '{m, r, w, x, a, l};
        return u;
    endfunction

    // Each slope is multiply / round / write back; a y update the same.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t u;
        u = UC_NOP;
        unique case (pc)
            // Euler
            6'd0:  u = mk(MUL_NONE, RND_NONE, WB_NONE, XE_START, ACC_NONE, 1'b0);
            6'd1:  u = mk(MUL_XX,   RND_NONE, WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd2:  u = mk(MUL_NONE, RND_F,    WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd3:  u = mk(MUL_NONE, RND_NONE, WB_K,    XE_NONE,  ACC_NONE, 1'b0);
            6'd4:  u = mk(MUL_HK,   RND_NONE, WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd5:  u = mk(MUL_NONE, RND_F,    WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd6:  u = mk(MUL_NONE, RND_NONE, WB_Y,    XE_NONE,  ACC_NONE, 1'b1);
            // Heun
            6'd7:  u = mk(MUL_NONE, RND_NONE, WB_NONE, XE_START, ACC_NONE, 1'b0);
            6'd8:  u = mk(MUL_XX,   RND_NONE, WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd9:  u = mk(MUL_NONE, RND_F,    WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd10: u = mk(MUL_NONE, RND_NONE, WB_K,    XE_NONE,  ACC_NONE, 1'b0);
            6'd11: u = mk(MUL_HK,   RND_NONE, WB_NONE, XE_FULL,  ACC_LOAD, 1'b0);
            6'd12: u = mk(MUL_NONE, RND_F,    WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd13: u = mk(MUL_NONE, RND_NONE, WB_YE,   XE_NONE,  ACC_NONE, 1'b0);
            6'd14: u = mk(MUL_XX,   RND_NONE, WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd15: u = mk(MUL_NONE, RND_F,    WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd16: u = mk(MUL_NONE, RND_NONE, WB_K,    XE_NONE,  ACC_NONE, 1'b0);
            6'd17: u = mk(MUL_NONE, RND_NONE, WB_NONE, XE_NONE,  ACC_ADD1, 1'b0);
            6'd18: u = mk(MUL_HS,   RND_NONE, WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd19: u = mk(MUL_NONE, RND_F1,   WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd20: u = mk(MUL_NONE, RND_NONE, WB_Y,    XE_NONE,  ACC_NONE, 1'b1);
            // classic RK4
            6'd21: u = mk(MUL_NONE, RND_NONE, WB_NONE, XE_START, ACC_NONE, 1'b0);
            6'd22: u = mk(MUL_XX,   RND_NONE, WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd23: u = mk(MUL_NONE, RND_F,    WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd24: u = mk(MUL_NONE, RND_NONE, WB_K,    XE_NONE,  ACC_NONE, 1'b0);
            6'd25: u = mk(MUL_HK,   RND_NONE, WB_NONE, XE_MID,   ACC_LOAD, 1'b0);
            6'd26: u = mk(MUL_NONE, RND_F1,   WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd27: u = mk(MUL_NONE, RND_NONE, WB_YE,   XE_NONE,  ACC_NONE, 1'b0);
            6'd28: u = mk(MUL_XX,   RND_NONE, WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd29: u = mk(MUL_NONE, RND_F,    WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd30: u = mk(MUL_NONE, RND_NONE, WB_K,    XE_NONE,  ACC_NONE, 1'b0);
            6'd31: u = mk(MUL_HK,   RND_NONE, WB_NONE, XE_NONE,  ACC_ADD2, 1'b0);
            6'd32: u = mk(MUL_NONE, RND_F1,   WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd33: u = mk(MUL_NONE, RND_NONE, WB_YE,   XE_NONE,  ACC_NONE, 1'b0);
            6'd34: u = mk(MUL_XX,   RND_NONE, WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd35: u = mk(MUL_NONE, RND_F,    WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd36: u = mk(MUL_NONE, RND_NONE, WB_K,    XE_NONE,  ACC_NONE, 1'b0);
            6'd37: u = mk(MUL_HK,   RND_NONE, WB_NONE, XE_FULL,  ACC_ADD2, 1'b0);
            6'd38: u = mk(MUL_NONE, RND_F,    WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd39: u = mk(MUL_NONE, RND_NONE, WB_YE,   XE_NONE,  ACC_NONE, 1'b0);
            6'd40: u = mk(MUL_XX,   RND_NONE, WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd41: u = mk(MUL_NONE, RND_F,    WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd42: u = mk(MUL_NONE, RND_NONE, WB_K,    XE_NONE,  ACC_NONE, 1'b0);
            6'd43: u = mk(MUL_NONE, RND_NONE, WB_NONE, XE_NONE,  ACC_ADD1, 1'b0);
            6'd44: u = mk(MUL_HS,   RND_NONE, WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd45: u = mk(MUL_NONE, RND_F,    WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd46: u = mk(MUL_NONE, RND_NONE, WB_P,    XE_NONE,  ACC_NONE, 1'b0);
            6'd47: u = mk(MUL_PR,   RND_NONE, WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd48: u = mk(MUL_NONE, RND_R6,   WB_NONE, XE_NONE,  ACC_NONE, 1'b0);
            6'd49: u = mk(MUL_NONE, RND_NONE, WB_YRAW, XE_NONE,  ACC_NONE, 1'b1);
            default: u = UC_NOP;
        endcase
        return u;
    endfunction

endpackage

// ----- rtl/ode_integrator_euler_rk2_rk4.sv -----
// ----------------------------------------------------------------------------
// ODE integrator, Euler / Heun / RK4
// Fixed-step solver for y' = x*x + y in signed Q16.16, microcoded datapath.
// ----------------------------------------------------------------------------
// Each item carries a start point (start_x, start_y); the block runs
// min(step_count, 1024) steps of size step_size with the method selected
// (0 Euler, 1 Heun, 2 and 3 classic RK4) and returns end_x, end_y and a sticky
// overflow flag that is set when any intermediate saturated during that run.
// Work is driven by a microcode ROM: one control word per cycle steers a
// single 38x33 signed multiplier, a registered round stage and a saturating
// writeback adder. Every multiply goes multiply -> round -> writeback, and
// this chain sets the rate. A zero step count returns the start point
// through the drain state and the output register. Only one item is in
// flight; a finished result sits in the output register and the next item
// is accepted while it waits. Configuration writes are always taken
// (cfg_ready is tied high) and must only be issued while idle.
// ----------------------------------------------------------------------------
`include "ode_integrator_euler_rk2_rk4_macros.svh"

module ode_integrator_euler_rk2_rk4
    import ode_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] start_x, [63:32] start_y
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata     // [31:0] end_x, [63:32] end_y, [64] overflow
);

    // configuration registers
    logic [1:0]        method_reg;
    logic [16:0]       step_size_reg;
    logic [STEP_W-1:0] step_count_reg;

    // sequencer
    state_t            state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [STEP_W-1:0] count_reg, count_next;
    logic [STEP_W-1:0] n_steps;
    logic [PC_W-1:0]   entry_pc;
    ucode_t            uc;
    logic              accept;
    logic              out_load;

    // datapath
    logic [31:0] x_reg, y_reg;      // working point
    logic [31:0] xe_reg, ye_reg;    // point where the slope is evaluated
    logic [31:0] k_reg;             // last slope
    logic [34:0] acc_reg;           // weighted slope sum
    logic [37:0] p_reg;             // clamped RK4 increment
    logic [63:0] prod_reg;
    logic [47:0] r_reg;             // rounded product
    logic        sat_reg;

    // result register
    logic        out_valid_reg;
    logic [31:0] end_x_reg, end_y_reg;
    logic        end_ovf_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'b0, end_ovf_reg, end_y_reg, end_x_reg};

    assign n_steps = (step_count_reg > MAX_STEPS) ? MAX_STEPS : step_count_reg;
    assign uc      = (state_reg == ST_RUN) ? ucode_rom(pc_reg) : UC_NOP;
    assign out_load = (state_reg == ST_DRAIN) && (!out_valid_reg || m_tready);

    always_comb
    begin
        unique case (method_reg)
            METH_EULER: entry_pc = PC_EULER;
            METH_HEUN:  entry_pc = PC_HEUN;
            default:    entry_pc = PC_RK4;   // code 3 runs RK4 as well
        endcase
    end

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg     <= METH_RK4;
            step_size_reg  <= 17'd6554;
            step_count_reg <= 11'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_METHOD:     method_reg     <= cfg_data[1:0];
                CFG_STEP_SIZE:  step_size_reg  <= cfg_data;
                CFG_STEP_COUNT: step_count_reg <= cfg_data[STEP_W-1:0];
                default:        ;   // no register here
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer: state, program counter, step counter
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    pc_next    = entry_pc;
                    count_next = '0;
                    state_next = (n_steps == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (uc.last)
                begin
                    count_next = count_reg + 1'b1;
                    pc_next    = entry_pc;
                    if (count_next == n_steps)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            count_reg <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // shared multiplier
    // ------------------------------------------------------------------
    logic signed [37:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [70:0] mul_full;

    always_comb
    begin
        unique case (uc.mul)
            MUL_XX:
            begin
                mul_a = {{6{xe_reg[31]}}, xe_reg};
                mul_b = {xe_reg[31], xe_reg};
            end
            MUL_HK:
            begin
                mul_a = {{6{k_reg[31]}}, k_reg};
                mul_b = {16'b0, step_size_reg};
            end
            MUL_HS:
            begin
                mul_a = {{3{acc_reg[34]}}, acc_reg};
                mul_b = {16'b0, step_size_reg};
            end
            MUL_PR:
            begin
                mul_a = p_reg;
                mul_b = 33'(RECIP6);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;   // all products used fit in 64 bits

    // ------------------------------------------------------------------
    // round half up: add half an LSB, arithmetic shift
    // ------------------------------------------------------------------
    logic signed [64:0] prod_ext;
    logic signed [64:0] rnd_shift;

    assign prod_ext = {prod_reg[63], prod_reg};

    always_comb
    begin
        unique case (uc.rnd)
            RND_F:   rnd_shift = (prod_ext + (65'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            RND_F1:  rnd_shift = (prod_ext + (65'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
            RND_R6:  rnd_shift = (prod_ext + (65'sd1 <<< (RECIP6_SHIFT - 1))) >>> RECIP6_SHIFT;
            default: rnd_shift = prod_ext;
        endcase
    end

    // ------------------------------------------------------------------
    // writeback: base + sat(r) (or + r for the last RK4 add), saturated
    // ------------------------------------------------------------------
    logic [48:0] r_ext;
    logic [31:0] r_sat;
    logic [31:0] wb_base;
    logic [48:0] wb_sum;
    logic [31:0] wb_res;
    logic        wb_ovf;

    localparam logic signed [47:0] P_LIMIT = 48'sd1 <<< 36;
    logic [37:0] p_clamp;

    assign r_ext   = {r_reg[47], r_reg};
    assign r_sat   = sat_val(r_ext);
    assign wb_base = (uc.wb == WB_K) ? ye_reg : y_reg;
    assign wb_sum  = {{17{wb_base[31]}}, wb_base}
                   + ((uc.wb == WB_YRAW) ? r_ext : {{17{r_sat[31]}}, r_sat});
    assign wb_res  = sat_val(wb_sum);
    assign wb_ovf  = ((uc.wb != WB_YRAW) && sat_ovf(r_ext)) || sat_ovf(wb_sum);

    always_comb
    begin
        if ($signed(r_reg) > P_LIMIT)
        begin
            p_clamp = P_LIMIT[37:0];
        end
        else if ($signed(r_reg) < -P_LIMIT)
        begin
            p_clamp = 38'(-P_LIMIT);
        end
        else
        begin
            p_clamp = r_reg[37:0];
        end
    end

    // ------------------------------------------------------------------
    // x adder: x + h, or x + h/2 rounded up for the RK4 midpoint
    // ------------------------------------------------------------------
    logic [16:0] h_half;
    logic [16:0] h_sel;
    logic [48:0] x_sum;
    logic [31:0] x_res;
    logic        x_ovf;
    logic        x_used;

    assign h_half = 17'((18'(step_size_reg) + 18'd1) >> 1);
    assign h_sel  = (uc.xe == XE_MID) ? h_half : step_size_reg;
    assign x_sum  = {{17{x_reg[31]}}, x_reg} + {32'b0, h_sel};
    assign x_res  = sat_val(x_sum);
    assign x_ovf  = sat_ovf(x_sum);
    assign x_used = uc.last || (uc.xe == XE_MID) || (uc.xe == XE_FULL);

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= s_tdata[31:0];
            y_reg <= s_tdata[63:32];
        end
        if (uc.mul != MUL_NONE)
        begin
            prod_reg <= mul_full[63:0];
        end
        if (uc.rnd != RND_NONE)
        begin
            r_reg <= rnd_shift[47:0];
        end
        unique case (uc.wb)
            WB_K:            k_reg  <= wb_res;
            WB_YE:           ye_reg <= wb_res;
            WB_Y, WB_YRAW:   y_reg  <= wb_res;
            WB_P:            p_reg  <= p_clamp;
            default:         ;
        endcase
        unique case (uc.xe)
            XE_START:
            begin
                xe_reg <= x_reg;
                ye_reg <= y_reg;
            end
            XE_MID, XE_FULL: xe_reg <= x_res;
            default:         ;
        endcase
        unique case (uc.acc)
            ACC_LOAD: acc_reg <= {{3{k_reg[31]}}, k_reg};
            ACC_ADD1: acc_reg <= acc_reg + {{3{k_reg[31]}}, k_reg};
            ACC_ADD2: acc_reg <= acc_reg + {{2{k_reg[31]}}, k_reg, 1'b0};
            default:  ;
        endcase
        if (uc.last)
        begin
            x_reg <= x_res;
        end
    end

    // sticky saturation flag for the current run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 1'b0;
        end
        else if (accept)
        begin
            sat_reg <= 1'b0;
        end
        else if (((uc.wb != WB_NONE) && (uc.wb != WB_P) && wb_ovf) || (x_used && x_ovf))
        begin
            sat_reg <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            end_x_reg   <= x_reg;
            end_y_reg   <= y_reg;
            end_ovf_reg <= sat_reg;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ODE_ASSERT_NOW(a_pc_in_rom, (state_reg == ST_RUN), (pc_reg < PC_W'(ROM_DEPTH)), "pc beyond microcode")
    `ODE_ASSERT_NOW(a_count_below_n, (state_reg == ST_RUN), (count_reg < n_steps), "step counter overran")
    `ODE_ASSERT_NEXT(a_flag_cleared, accept, (!sat_reg), "overflow flag not cleared on new item")
    `ODE_ASSERT_NEXT(a_drain_delivers, out_load, (out_valid_reg && (state_reg == ST_IDLE)), "result not loaded")

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Testbench for the Euler / Heun / RK4 ODE integrator
// Drives start points on the input stream, predicts each run in fixed point
// and compares end_x, end_y and the overflow flag of every result item.
// ----------------------------------------------------------------------------
module tb_top;
    import ode_pkg::*;

    localparam int     CLK_HALF     = 5;
    localparam longint WATCHDOG_T   = 100_000_000;  // watchdog timeout
    localparam int     REPORT_LIMIT = 10;

    // codes the package does not name
    localparam logic [1:0] METH_RK4_ALT = 2'd3;     // spare method code, runs RK4
    localparam logic [1:0] CFG_SPARE    = 2'd3;     // unmapped register index

    // signed 32-bit range and the RK4 increment clamp
    localparam longint Q_HI  = 64'sd2147483647;
    localparam longint Q_LO  = -64'sd2147483648;
    localparam longint P_CAP = 64'sd68719476736;    // 2^36

    typedef struct {
        logic [31:0] end_x;
        logic [31:0] end_y;
        logic        ovf;
    } run_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [16:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;    // [31:0] start_x, [63:32] start_y
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;           // [31:0] end_x, [63:32] end_y, [64] overflow

    // register copies, loaded with the reset values of the block
    logic [1:0]  mirror_method     = METH_RK4;
    logic [16:0] mirror_step_size  = 17'd6554;
    logic [10:0] mirror_step_count = 11'd10;

    bit          sat_hit;           // sticky saturation flag of the run being predicted
    run_result_t pending_runs[$];   // predicted results, oldest first

    int mismatches     = 0;
    int results_seen   = 0;
    int items_sent     = 0;
    int sat_runs       = 0;
    int settings_used  = 0;
    int runs_by_method[4] = '{0, 0, 0, 0};

    int rx_hold_req = 0;            // cycles the result side must hold off
    bit rx_jitter   = 1'b1;         // random m_tready gaps on/off
    bit tx_jitter   = 1'b1;         // random s_tvalid gaps on/off

    ode_integrator_euler_rk2_rk4 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------------

    // add half an LSB, then arithmetic shift (floor)
    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    // saturate to signed 32 bits, remembering that it happened
    function automatic longint clamp_q(input longint v);
        if (v > Q_HI)
        begin
            sat_hit = 1'b1;
            return Q_HI;
        end
        if (v < Q_LO)
        begin
            sat_hit = 1'b1;
            return Q_LO;
        end
        return v;
    endfunction

    // y' = x*x + y
    function automatic longint eval_slope(input longint x, input longint y);
        return clamp_q(clamp_q(round_shift(x * x, FRAC_BITS)) + y);
    endfunction

    // whole run of one item under the current register copies
    function automatic run_result_t integrate_run(input logic [31:0] sx,
                                                  input logic [31:0] sy);
        run_result_t r;
        longint h, x, y, xm, xf, k1, k2, k3, k4, acc, p;
        int n;
        h = longint'(mirror_step_size);
        x = longint'(signed'(sx));
        y = longint'(signed'(sy));
        n = (mirror_step_count > MAX_STEPS) ? int'(MAX_STEPS) : int'(mirror_step_count);
        sat_hit = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            case (mirror_method)
                METH_EULER:
                begin
                    k1 = eval_slope(x, y);
                    y  = clamp_q(y + clamp_q(round_shift(h * k1, FRAC_BITS)));
                end
                METH_HEUN:
                begin
                    k1  = eval_slope(x, y);
                    xf  = clamp_q(x + h);
                    k2  = eval_slope(xf, clamp_q(y + clamp_q(round_shift(h * k1, FRAC_BITS))));
                    acc = k1 + k2;
                    // the 1/2 of the average is the extra shift
                    y   = clamp_q(y + clamp_q(round_shift(h * acc, FRAC_BITS + 1)));
                end
                default:    // classic RK4, also the spare code
                begin
                    xm  = clamp_q(x + ((h + 1) >>> 1));
                    k1  = eval_slope(x, y);
                    k2  = eval_slope(xm, clamp_q(y + clamp_q(round_shift(h * k1, FRAC_BITS + 1))));
                    k3  = eval_slope(xm, clamp_q(y + clamp_q(round_shift(h * k2, FRAC_BITS + 1))));
                    xf  = clamp_q(x + h);
                    k4  = eval_slope(xf, clamp_q(y + clamp_q(round_shift(h * k3, FRAC_BITS))));
                    acc = k1 + 2 * k2 + 2 * k3 + k4;
                    p   = round_shift(h * acc, FRAC_BITS);
                    if (p > P_CAP)
                        p = P_CAP;
                    if (p < -P_CAP)
                        p = -P_CAP;
                    // divide by 6 through the reciprocal
                    y   = clamp_q(y + round_shift(p * RECIP6, RECIP6_SHIFT));
                end
            endcase
            x = clamp_q(x + h);
        end
        r.end_x = x[31:0];
        r.end_y = y[31:0];
        r.ovf   = sat_hit;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random picks
    // ------------------------------------------------------------------------

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(21, 100);
    endfunction

    // small values keep the solution in range; corners and full-range words mixed in
    function automatic logic [31:0] pick_operand();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 6))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                4:       return 32'h0000_0001;
                5:       return 32'h0001_0000;
                default: return 32'hFFFF_0000;
            endcase
        end
        if (r < 3)
            return $urandom();
        // about +-4.0 in Q16.16
        return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endfunction

    function automatic logic [16:0] pick_step_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return 17'h1_0000;
        if (r == 2)
            return 17'($urandom());
        if (r < 10)
            return 17'($urandom_range(1, 65536));
        return 17'($urandom_range(1, 8192));
    endfunction

    // short runs keep the test quick; zero and longer counts now and then
    function automatic logic [10:0] pick_step_count();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return 11'($urandom_range(13, 40));
        return 11'($urandom_range(1, 12));
    endfunction

    // ------------------------------------------------------------------------
    // Stream and register drivers
    // ------------------------------------------------------------------------

    // Offer one start point, wait for the handshake, queue the prediction.
    task automatic send_item(input logic [31:0] sx, input logic [31:0] sy);
        int gap;
        run_result_t want;
        gap = tx_jitter ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sy, sx};
        do @(posedge clk); while (s_tready !== 1'b1);
        want = integrate_run(sx, sy);
        pending_runs.push_back(want);
        items_sent++;
        runs_by_method[mirror_method]++;
        if (want.ovf)
            sat_runs++;
    endtask

    // Stop offering and let every outstanding result come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write; cfg_valid stays up for a following write.
    task automatic cfg_write(input logic [1:0] idx, input logic [16:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_METHOD:     mirror_method     = d[1:0];
            CFG_STEP_SIZE:  mirror_step_size  = d;
            CFG_STEP_COUNT: mirror_step_count = d[10:0];
            default:        ;
        endcase
    endtask

    // Write all three registers while the block is idle. Unused upper bits of
    // the method and count words sometimes carry junk, which must be ignored.
    task automatic apply_config(input logic [1:0] m, input logic [16:0] h,
                                input logic [10:0] n);
        logic [16:0] junk;
        wait_idle();
        junk = $urandom_range(0, 1) ? 17'($urandom()) : '0;
        cfg_write(CFG_METHOD, {junk[16:2], m});
        cfg_write(CFG_STEP_SIZE, h);
        cfg_write(CFG_STEP_COUNT, {junk[16:11], n});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic config_and_send(input logic [1:0] m, input logic [16:0] h,
                                   input logic [10:0] n, input logic [31:0] sx,
                                   input logic [31:0] sy);
        apply_config(m, h, n);
        send_item(sx, sy);
    endtask

    // ------------------------------------------------------------------------
    // Result side: m_tready with random gaps and requested long holds
    // ------------------------------------------------------------------------
    initial
    begin : ready_driver
        int gap_left;
        int hold_left;
        gap_left  = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req > 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                m_tready <= 1'b0;
                gap_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (rx_jitter && $urandom_range(0, 3) == 0)
                    gap_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted result against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        run_result_t want;
        logic [31:0] got_x;
        logic [31:0] got_y;
        logic        got_ovf;
        if (rst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            got_x   = m_tdata[31:0];
            got_y   = m_tdata[63:32];
            got_ovf = m_tdata[64];
            results_seen++;
            if (pending_runs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result item: x=%h y=%h ovf=%b",
                             got_x, got_y, got_ovf);
            end
            else
            begin
                want = pending_runs.pop_front();
                if (got_x !== want.end_x || got_y !== want.end_y || got_ovf !== want.ovf)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result %0d mismatch: expected x=%h y=%h ovf=%b, got x=%h y=%h ovf=%b",
                                 results_seen, want.end_x, want.end_y, want.ovf,
                                 got_x, got_y, got_ovf);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset setting: RK4, h = 0.1, 10 steps
    task automatic test_reset_defaults();
        send_item(32'h0000_0000, 32'h0000_0000);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(32'h8000_0000, 32'h8000_0000);
        send_item(32'h0001_0000, 32'h0001_0000);
    endtask

    // Result side holds off long enough for the block to fill and stall its
    // input while items keep coming.
    task automatic test_output_stall();
        wait_idle();
        tx_jitter   = 1'b0;
        rx_hold_req = 2000;
        for (int i = 0; i < 6; i++)
            send_item(pick_operand(), pick_operand());
        tx_jitter   = 1'b1;
    endtask

    task automatic test_special_cases();
        // each method at a moderate step
        config_and_send(METH_EULER, 17'd6554, 11'd10, 32'h0000_8000, 32'hFFFF_0000);
        send_item(32'hFFFF_FFFF, 32'h0000_0001);
        config_and_send(METH_HEUN, 17'd6554, 11'd10, 32'h0001_0000, 32'h0000_0000);
        send_item(32'h8000_0000, 32'h7FFF_FFFF);
        // spare method code behaves as RK4
        config_and_send(METH_RK4_ALT, 17'd6554, 11'd10, 32'h0001_0000, 32'h0000_0000);
        // no steps: start point comes straight back
        config_and_send(METH_RK4, 17'd6554, 11'd0, 32'h1234_5678, 32'h9ABC_DEF0);
        config_and_send(METH_EULER, 17'd6554, 11'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        // count beyond the step limit, then exactly at it
        config_and_send(METH_EULER, 17'd64, 11'd2047, 32'hFFFF_0000, 32'h0000_0100);
        config_and_send(METH_RK4, 17'd64, 11'd1024, 32'h0000_0000, 32'h0001_0000);
        // zero step: nothing moves
        config_and_send(METH_HEUN, 17'd0, 11'd5, 32'h0002_0000, 32'h0003_0000);
        config_and_send(METH_RK4, 17'd0, 11'd5, 32'hFFFE_0000, 32'hFFFD_0000);
        config_and_send(METH_EULER, 17'd0, 11'd3, 32'h7FFF_FFFF, 32'h0000_0000);
        // full unit step, huge RK4 increments in both directions
        config_and_send(METH_RK4, 17'h1_0000, 11'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(32'h0000_0000, 32'h8000_0000);
        // widest step word, smallest step
        config_and_send(METH_EULER, 17'h1_FFFF, 11'd3, 32'h0000_4000, 32'hFFFF_C000);
        config_and_send(METH_HEUN, 17'd1, 11'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // write to the unmapped index must leave the setting alone
        wait_idle();
        cfg_write(CFG_SPARE, 17'h1_FFFF);
        cfg_valid <= 1'b0;
        send_item(32'h0001_8000, 32'hFFFE_8000);
    endtask

    // sender stops mid-stream until all results are back, then carries on
    task automatic test_sender_pause();
        apply_config(METH_HEUN, 17'd3277, 11'd6);
        for (int i = 0; i < 10; i++)
            send_item(pick_operand(), pick_operand());
        wait_idle();
        for (int i = 0; i < 10; i++)
            send_item(pick_operand(), pick_operand());
    endtask

    task automatic test_random_runs(input int phases, input int per_phase);
        logic [1:0]  m;
        logic [16:0] h;
        logic [10:0] n;
        for (int ph = 0; ph < phases; ph++)
        begin
            m = 2'($urandom_range(0, 3));
            h = pick_step_size();
            n = pick_step_count();
            apply_config(m, h, n);
            // some phases run with one or both sides never idling
            rx_jitter = ($urandom_range(0, 4) != 0);
            tx_jitter = ($urandom_range(0, 4) != 0);
            for (int i = 0; i < per_phase; i++)
                send_item(pick_operand(), pick_operand());
        end
        rx_jitter = 1'b1;
        tx_jitter = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_output_stall();
        test_special_cases();
        test_sender_pause();
        test_random_runs(40, 42);

        // all results back, then a short tail for anything stray
        wait_idle();
        repeat (20) @(posedge clk);

        $display("Ran %0d items (Euler %0d, Heun %0d, RK4 %0d, spare code %0d) over %0d settings,",
                 items_sent, runs_by_method[0], runs_by_method[1], runs_by_method[2],
                 runs_by_method[3], settings_used);
        $display("%0d runs saturated, %0d results checked, %0d mismatches.",
                 sat_runs, results_seen, mismatches);
        if (mismatches == 0 && pending_runs.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #(WATCHDOG_T);
        $display("timeout: %0d results still pending", pending_runs.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
